/* sv/hfg_pkg.sv */
`default_nettype none
package hfg_pkg;

	localparam logic [7:0]  STX         = 8'hFD;
	localparam logic [7:0]  PAYLOAD_LEN = 8'd9;
	localparam logic [7:0]  CRC_EXTRA   = 8'd50;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [7:0]  MAV_VERSION = 8'd3;
	localparam logic [31:0] PERIOD_RST  = 32'd1000;
	localparam int          FRM_BYTES   = 21;
	localparam int          POS_W       = $clog2(FRM_BYTES);
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRM_BYTES - 1);
	localparam logic [POS_W-1:0] POS_CRC_LO   = POS_W'(FRM_BYTES - 2);
	localparam logic [POS_W-1:0] POS_LAST_CRC = POS_W'(FRM_BYTES - 3);

	// configuration register indexes
	typedef enum logic [3:0] {
		REG_SYSTEM_ID      = 4'd0,
		REG_COMPONENT_ID   = 4'd1,
		REG_VEHICLE_TYPE   = 4'd2,
		REG_AUTOPILOT_KIND = 4'd3,
		REG_MODE_FLAGS     = 4'd4,
		REG_SYS_STATE      = 4'd5,
		REG_CUST_WORD      = 4'd6,
		REG_PERIOD_MS      = 4'd7
	} hfg_reg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        link_ready;
	} hfg_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} hfg_out_t;

	// one frame to send, with config captured at request time
	typedef struct packed {
		logic [7:0]  seq;
		logic [7:0]  system_id;
		logic [7:0]  component_id;
		logic [7:0]  vehicle_type;
		logic [7:0]  autopilot_kind;
		logic [7:0]  mode_flags;
		logic [7:0]  sys_state;
		logic [31:0] cust_word;
	} hfg_desc_t;

	// CRC-16/MCRF4XX, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
	endfunction

endpackage
`default_nettype wire

/* sv/hfg_front.sv */
`default_nettype none
module hfg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hfg_pkg::hfg_in_t  item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              q_push,
	output hfg_pkg::hfg_desc_t q_desc,
	input  logic              q_full
);
	import hfg_pkg::*;

	logic [7:0]  system_id_q, component_id_q, vehicle_type_q, autopilot_kind_q;
	logic [7:0]  mode_flags_q, sys_state_q;
	logic [31:0] cust_word_q, period_ms_q;

	logic [7:0]  seq_q;
	logic [31:0] last_send_q;
	logic        first_q;

	logic        accept;
	logic        due;
	logic [31:0] elapsed;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign elapsed   = item.now_ms - last_send_q;
	assign due       = first_q || (elapsed >= period_ms_q);
	assign q_push    = accept && due && item.link_ready;

	always_comb begin
		q_desc.seq            = seq_q;
		q_desc.system_id      = system_id_q;
		q_desc.component_id   = component_id_q;
		q_desc.vehicle_type   = vehicle_type_q;
		q_desc.autopilot_kind = autopilot_kind_q;
		q_desc.mode_flags     = mode_flags_q;
		q_desc.sys_state      = sys_state_q;
		q_desc.cust_word      = cust_word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			system_id_q      <= 8'd1;
			component_id_q   <= 8'd1;
			vehicle_type_q   <= 8'd0;
			autopilot_kind_q <= 8'd0;
			mode_flags_q     <= 8'd1;
			sys_state_q      <= 8'd4;
			cust_word_q      <= 32'd0;
			period_ms_q      <= PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (hfg_reg_t'(cfg_index))
				REG_SYSTEM_ID:      system_id_q      <= cfg_data[7:0];
				REG_COMPONENT_ID:   component_id_q   <= cfg_data[7:0];
				REG_VEHICLE_TYPE:   vehicle_type_q   <= cfg_data[7:0];
				REG_AUTOPILOT_KIND: autopilot_kind_q <= cfg_data[7:0];
				REG_MODE_FLAGS:     mode_flags_q     <= cfg_data[7:0];
				REG_SYS_STATE:      sys_state_q      <= cfg_data[7:0];
				REG_CUST_WORD:      cust_word_q      <= cfg_data;
				REG_PERIOD_MS:      period_ms_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= 8'd0;
			last_send_q <= 32'd0;
			first_q     <= 1'b1;
		end else if (accept && due) begin
			// sequence advances even when the link drops the frame
			seq_q <= seq_q + 8'd1;
			if (item.link_ready) begin
				last_send_q <= item.now_ms;
				first_q     <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/hfg_queue.sv */
`default_nettype none
module hfg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  hfg_pkg::hfg_desc_t wr_desc,
	output logic               q_full,
	input  logic               rd,
	output hfg_pkg::hfg_desc_t rd_desc,
	output logic               rd_valid
);
	import hfg_pkg::*;

	hfg_desc_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign q_full   = count_q[1];
	assign rd_valid = (count_q != 2'd0);
	assign rd_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/hfg_back.sv */
`default_nettype none
module hfg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               desc_valid,
	input  hfg_pkg::hfg_desc_t desc,
	output logic               desc_pop,
	output logic               empty,
	input  logic               pop,
	output hfg_pkg::hfg_out_t  result
);
	import hfg_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	hfg_out_t         out_q;
	logic             out_valid_q;

	logic             advance;
	logic [7:0]       cur_byte;
	logic [15:0]      crc_final;

	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign advance   = desc_valid && (!out_valid_q || pop);
	assign desc_pop  = advance && (pos_q == POS_LAST);
	assign crc_final = crc_step(crc_q, CRC_EXTRA);

	always_comb begin
		case (pos_q)
			5'd0:       cur_byte = STX;
			5'd1:       cur_byte = PAYLOAD_LEN;
			5'd4:       cur_byte = desc.seq;
			5'd5:       cur_byte = desc.system_id;
			5'd6:       cur_byte = desc.component_id;
			5'd10:      cur_byte = desc.cust_word[7:0];
			5'd11:      cur_byte = desc.cust_word[15:8];
			5'd12:      cur_byte = desc.cust_word[23:16];
			5'd13:      cur_byte = desc.cust_word[31:24];
			5'd14:      cur_byte = desc.vehicle_type;
			5'd15:      cur_byte = desc.autopilot_kind;
			5'd16:      cur_byte = desc.mode_flags;
			5'd17:      cur_byte = desc.sys_state;
			5'd18:      cur_byte = MAV_VERSION;
			POS_CRC_LO: cur_byte = crc_final[7:0];
			POS_LAST:   cur_byte = crc_final[15:8];
			default:    cur_byte = 8'h00; // flags and message id
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.frame_byte <= cur_byte;
			out_q.frame_end  <= (pos_q == POS_LAST);
			if (pos_q == '0) begin
				crc_q <= CRC_INIT;
			end else if (pos_q <= POS_LAST_CRC) begin
				crc_q <= crc_step(crc_q, cur_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				pos_q       <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/heartbeat_frame_generator.sv */
`default_nettype none
// Periodic MAVLink v2 HEARTBEAT framer. One time request (now_ms, link_ready) is taken per
// cycle while full is low; a request that finds a frame due and the link ready queues a
// 21-byte frame (header, 9-byte payload, CRC-16/MCRF4XX low byte first), which comes out
// one byte per cycle while pop is held, frame_end marking the CRC high byte. An accepted
// request is first written into the frame queue, and the serializer then registers its
// first byte onto the result ports. A two-entry frame queue sits between the request side
// and the byte serializer, and the frame being serialized keeps its entry until its last
// byte is loaded; full is high only while both entries are taken, so sustained throughput
// is set by the one-byte-per-cycle serializer. Configuration writes are always ready
// and take effect on the next request; the frame fields are captured when the frame is
// queued.
module heartbeat_frame_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hfg_pkg::hfg_in_t  item,
	output logic              empty,
	input  logic              pop,
	output hfg_pkg::hfg_out_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import hfg_pkg::*;

	logic      q_push, q_full, q_pop, q_valid;
	hfg_desc_t q_wr_desc, q_rd_desc;

	hfg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_desc    (q_wr_desc),
		.q_full    (q_full)
	);

	hfg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_desc  (q_wr_desc),
		.q_full   (q_full),
		.rd       (q_pop),
		.rd_desc  (q_rd_desc),
		.rd_valid (q_valid)
	);

	hfg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_valid),
		.desc       (q_rd_desc),
		.desc_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
`default_nettype wire

/* sv/hfg_checker.sv */
`default_nettype none
module hfg_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic              empty,
	input  logic              pop,
	input  hfg_pkg::hfg_out_t result
);
	import hfg_pkg::*;

	// position of the waiting result inside its frame
	logic [POS_W-1:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (pop && !empty) begin
			pos_q <= result.frame_end ? '0 : pos_q + POS_W'(1);
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (pos_q == '0) |-> result.frame_byte == STX)
		else $error("frame does not start with STX");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.frame_end == (pos_q == POS_LAST))
		else $error("frame_end not on last byte");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without a request");

endmodule

bind heartbeat_frame_generator hfg_checker u_chk (.*);
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
	import hfg_pkg::*;

	// reflected form of the CCITT polynomial, used by CRC-16/MCRF4XX
	localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
	// register indexes past the end of the map; writes there are dropped
	localparam logic [3:0]  REG_NONE_LO   = 4'd8;
	localparam logic [3:0]  REG_NONE_HI   = 4'd15;
	localparam int          LIMIT_CYCLES  = 600000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	hfg_in_t     item;
	logic        empty;
	logic        pop;
	hfg_out_t    result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the configuration and framer state
	logic [7:0]  hb_sysid;
	logic [7:0]  hb_compid;
	logic [7:0]  hb_vtype;
	logic [7:0]  hb_autopilot;
	logic [7:0]  hb_mode;
	logic [7:0]  hb_status;
	logic [31:0] hb_custom;
	logic [31:0] hb_period;
	logic [7:0]  hb_seq;
	logic [31:0] hb_last_sent;
	logic        hb_first;

	hfg_out_t    frame_q[$];
	int          errors        = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          hold_left     = 0;

	heartbeat_frame_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("** heartbeat_frame_generator: FAILED **");
		$finish;
	end

	// returns 1 when the request makes a heartbeat due; queues the bytes if it is sent
	function automatic bit predict_heartbeat(input hfg_in_t req);
		logic [7:0]  f [FRM_BYTES];
		logic [7:0]  b;
		logic [15:0] crc;
		int          i;
		int          k;
		if (!hb_first && 32'(req.now_ms - hb_last_sent) < hb_period)
			return 1'b0;
		f[0]  = STX;
		f[1]  = PAYLOAD_LEN;
		f[2]  = 8'h00;
		f[3]  = 8'h00;
		f[4]  = hb_seq;
		f[5]  = hb_sysid;
		f[6]  = hb_compid;
		f[7]  = 8'h00;
		f[8]  = 8'h00;
		f[9]  = 8'h00;
		f[10] = hb_custom[7:0];
		f[11] = hb_custom[15:8];
		f[12] = hb_custom[23:16];
		f[13] = hb_custom[31:24];
		f[14] = hb_vtype;
		f[15] = hb_autopilot;
		f[16] = hb_mode;
		f[17] = hb_status;
		f[18] = MAV_VERSION;
		hb_seq = hb_seq + 8'd1;
		if (!req.link_ready)
			return 1'b1;
		// CRC over header after STX and payload, then the extra byte
		crc = CRC_INIT;
		for (i = 1; i < 20; i++) begin
			b = (i == 19) ? CRC_EXTRA : f[i];
			crc = crc ^ {8'h00, b};
			for (k = 0; k < 8; k++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_REFL) : (crc >> 1);
		end
		f[19] = crc[7:0];
		f[20] = crc[15:8];
		for (i = 0; i < FRM_BYTES; i++)
			frame_q.push_back('{frame_byte: f[i], frame_end: (i == FRM_BYTES - 1)});
		hb_last_sent = req.now_ms;
		hb_first = 1'b0;
		return 1'b1;
	endfunction

	// leaves push high so back-to-back requests need no lowering in between
	task automatic send_request(input logic [31:0] now, input logic ready);
		hfg_in_t req;
		req.now_ms = now;
		req.link_ready = ready;
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		do
			@(posedge clk);
		while (full);
		void'(predict_heartbeat(req));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		// requests that make no frame may still be in flight
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SYSTEM_ID:      hb_sysid = data[7:0];
			REG_COMPONENT_ID:   hb_compid = data[7:0];
			REG_VEHICLE_TYPE:   hb_vtype = data[7:0];
			REG_AUTOPILOT_KIND: hb_autopilot = data[7:0];
			REG_MODE_FLAGS:     hb_mode = data[7:0];
			REG_SYS_STATE:      hb_status = data[7:0];
			REG_CUST_WORD:      hb_custom = data;
			REG_PERIOD_MS:      hb_period = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all_regs(input logic [31:0] v, input logic [31:0] period);
		write_reg(REG_SYSTEM_ID, v);
		write_reg(REG_COMPONENT_ID, v);
		write_reg(REG_VEHICLE_TYPE, v);
		write_reg(REG_AUTOPILOT_KIND, v);
		write_reg(REG_MODE_FLAGS, v);
		write_reg(REG_SYS_STATE, v);
		write_reg(REG_CUST_WORD, v);
		write_reg(REG_PERIOD_MS, period);
	endtask

	task automatic randomize_config();
		write_reg(REG_SYSTEM_ID, $urandom());
		write_reg(REG_COMPONENT_ID, $urandom());
		write_reg(REG_VEHICLE_TYPE, $urandom());
		write_reg(REG_AUTOPILOT_KIND, $urandom());
		write_reg(REG_MODE_FLAGS, $urandom());
		write_reg(REG_SYS_STATE, $urandom());
		write_reg(REG_CUST_WORD, $urandom());
		write_reg(REG_PERIOD_MS, ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1));
		write_reg(4'($urandom_range(REG_NONE_HI, REG_NONE_LO)), $urandom());
	endtask

	// reset values: first request always due, then the default period applies
	task automatic test_first_frame();
		send_request(32'd0, 1'b0);
		send_request(32'd5, 1'b1);
		send_request(32'd999, 1'b1);
		send_request(32'd1005, 1'b0);
		send_request(32'd1005, 1'b1);
		send_request(32'd2004, 1'b1);
		wait_idle();
	endtask

	task automatic test_time_wrap();
		send_request(32'hFFFF_FE00, 1'b1);
		send_request(32'h0000_01E7, 1'b1);
		send_request(32'h0000_01E8, 1'b1);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		logic [31:0] t;
		t = $urandom();
		set_all_regs(32'h0, 32'h0);
		// zero period: every request is due
		send_request(t, 1'b1);
		send_request(t, 1'b1);
		send_request(t, 1'b0);
		send_request(t, 1'b1);
		wait_idle();
		write_reg(REG_NONE_LO, 32'hFFFF_FFFF);
		write_reg(REG_NONE_HI, 32'hFFFF_FFFF);
		send_request(t, 1'b1);
		wait_idle();
		set_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(hb_last_sent - 32'd2, 1'b1);
		send_request(hb_last_sent - 32'd1, 1'b1);
		send_request(hb_last_sent + 32'hFFFF_FFFE, 1'b1);
		wait_idle();
	endtask

	// receiver holds off while requests keep coming, so the frame queue fills
	task automatic test_input_backpressure();
		logic [31:0] t;
		t = $urandom();
		write_reg(REG_PERIOD_MS, 32'd0);
		stall_pct = 0;
		send_idle_pct = 0;
		hold_left = 400;
		repeat (10) send_request(t, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int n);
		logic [31:0] t;
		send_idle_pct = idle;
		stall_pct = stall;
		randomize_config();
		t = $urandom();
		repeat (n) begin
			if ($urandom_range(99) < 12) begin
				send_request($urandom(), 1'($urandom_range(1)));
			end else begin
				t = t + $urandom_range(0, hb_period + hb_period / 2 + 1);
				send_request(t, $urandom_range(99) < 85);
			end
		end
		wait_idle();
	endtask

	// result checker and pop driver
	initial begin
		hfg_out_t want;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (frame_q.size() == 0) begin
					$error("unexpected frame_byte %h frame_end %b",
						result.frame_byte, result.frame_end);
					errors++;
				end else begin
					want = frame_q.pop_front();
					if (result.frame_byte !== want.frame_byte) begin
						$error("frame_byte: expected %h, got %h",
							want.frame_byte, result.frame_byte);
						errors++;
					end
					if (result.frame_end !== want.frame_end) begin
						$error("frame_end: expected %b, got %b",
							want.frame_end, result.frame_end);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hb_sysid = 8'd1;
		hb_compid = 8'd1;
		hb_vtype = 8'd0;
		hb_autopilot = 8'd0;
		hb_mode = 8'd1;
		hb_status = 8'd4;
		hb_custom = 32'd0;
		hb_period = PERIOD_RST;
		hb_seq = 8'd0;
		hb_last_sent = 32'd0;
		hb_first = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_frame();
		test_time_wrap();
		test_register_extremes();
		test_input_backpressure();
		test_random_traffic(0, 0, 100);
		test_random_traffic(77, 0, 100);
		test_random_traffic(0, 77, 100);
		test_random_traffic(34, 34, 100);

		send_idle_pct = 0;
		stall_pct = 0;
		wait_idle();
		repeat (32) @(posedge clk);
		if (errors == 0)
			$display("** heartbeat_frame_generator: PASSED **");
		else
			$display("** heartbeat_frame_generator: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
sv/hfg_pkg.sv
sv/hfg_front.sv
sv/hfg_queue.sv
sv/hfg_back.sv
sv/heartbeat_frame_generator.sv
sv/hfg_checker.sv
test/testbench.sv
